FILE: design/htw_pkg.sv
package htw_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int OPCODE_W  = 1;
   localparam int CHILD_W   = 9;
   localparam int SYM_W     = 8;
   localparam int BYTE_BITS = 8;

   // Mask of the code bit consumed next.
   localparam logic [BYTE_BITS-1:0] TOP_BIT = 8'h80;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_LOAD   = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_DECODE = 1'b1;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [CHILD_W-1:0]  node_index;
      logic [CHILD_W-1:0]  left_child;
      logic [CHILD_W-1:0]  right_child;
      logic                is_leaf;
      logic [SYM_W-1:0]    leaf_symbol;
      logic [BYTE_BITS-1:0] code_byte;
   } req_payload_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } rsp_payload_type;

   // One node of the code tree as it sits in the node table.
   typedef struct packed {
      logic [CHILD_W-1:0] left;
      logic [CHILD_W-1:0] right;
      logic               leaf;
      logic [SYM_W-1:0]   sym;
   } node_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic flush;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic bits_done;
      logic leaf_found;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

FILE: design/htw_stream_if.sv
interface htw_req_if;
   import htw_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface htw_rsp_if;
   import htw_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/htw_ctrl.sv
module htw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [0:0]            req_opcode,
   output logic                  req_ready,
   input  htw_pkg::dp_status_type status,
   output htw_pkg::ctrl_cmd_type  cmd
);
   import htw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // Hold the walk only when a symbol must move out and the output is full.
            if (!(status.leaf_found && status.pend_valid && !status.out_free)) begin
               cmd.step = 1'b1;
               if (status.bits_done) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/htw_datapath.sv
module htw_datapath #(
   parameter int NODE_COUNT = 512
) (
   input  logic                    clock,
   input  logic                    reset,
   input  htw_pkg::req_payload_type req_data,
   input  htw_pkg::ctrl_cmd_type    cmd,
   output htw_pkg::dp_status_type   status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output htw_pkg::rsp_payload_type rsp_data
);
   import htw_pkg::*;

   localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int CW = $clog2(BYTE_BITS + 1);

   node_entry_type mem [NODE_COUNT];

   node_entry_type rd_data_ff;
   node_entry_type root_ff, root_in;
   node_entry_type cur_ent_ff, cur_ent_in;
   node_entry_type walk_ent;
   node_entry_type load_ent;

   logic [AW-1:0] cur_idx_ff, cur_idx_in;
   logic [AW-1:0] nxt_idx_ff, nxt_idx_in;
   logic [AW-1:0] walk_idx;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] load_addr;

   logic eval_ff, eval_in;
   logic oor_ff, oor_in;
   logic load_hit;
   logic child_oor;
   logic found_leaf;
   logic issue;
   logic rd_en;
   logic bits_done;
   logic out_free;
   logic push;

   logic [CHILD_W-1:0]   child;
   logic [BYTE_BITS-1:0] shift_ff, shift_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   logic             pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0] pend_sym_ff, pend_sym_in;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   rsp_payload_type push_data;

   // Node written by a load request.
   assign load_ent = '{left:  req_data.left_child,
                       right: req_data.right_child,
                       leaf:  req_data.is_leaf,
                       sym:   req_data.leaf_symbol};
   assign load_addr = AW'(req_data.node_index);
   assign load_hit  = cmd.load && (32'(req_data.node_index) < NODE_COUNT);

   // Node table with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (load_hit) begin
         mem[load_addr] <= load_ent;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Resolve the node the walk stands on: a fresh read, or the root after a leaf or a
   // step out of range, or the node kept from the previous request.
   always_comb begin
      bits_done  = (cnt_ff == CW'(BYTE_BITS));
      found_leaf = eval_ff && !oor_ff && rd_data_ff.leaf;
      if (!eval_ff) begin
         walk_ent = cur_ent_ff;
         walk_idx = cur_idx_ff;
      end else if (oor_ff || rd_data_ff.leaf) begin
         walk_ent = root_ff;
         walk_idx = '0;
      end else begin
         walk_ent = rd_data_ff;
         walk_idx = nxt_idx_ff;
      end
      child     = ((shift_ff & TOP_BIT) != '0) ? walk_ent.right : walk_ent.left;
      child_oor = (32'(child) >= NODE_COUNT);
      rd_addr   = AW'(child);
      issue     = cmd.step && !bits_done;
      rd_en     = issue && !child_oor;
   end

   // Symbol that moves to the output register.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      push      = 1'b0;
      push_data = '{symbol: pend_sym_ff, last: 1'b0};
      if (cmd.step && found_leaf && pend_valid_ff) begin
         push = 1'b1;
      end
      if (cmd.flush) begin
         push           = 1'b1;
         push_data.last = 1'b1;
      end
   end

   // Next values of the walk state.
   always_comb begin
      cur_idx_in    = cur_idx_ff;
      cur_ent_in    = cur_ent_ff;
      root_in       = root_ff;
      nxt_idx_in    = nxt_idx_ff;
      eval_in       = eval_ff;
      oor_in        = oor_ff;
      shift_in      = shift_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;

      // A load keeps the cached root and current node in step with the table.
      if (load_hit && (load_addr == '0)) begin
         root_in = load_ent;
      end
      if (load_hit && (load_addr == cur_idx_ff)) begin
         cur_ent_in = load_ent;
      end

      if (cmd.start) begin
         shift_in = req_data.code_byte;
         cnt_in   = '0;
         eval_in  = 1'b0;
      end

      if (cmd.step) begin
         cur_idx_in = walk_idx;
         cur_ent_in = walk_ent;
         if (found_leaf) begin
            pend_valid_in = 1'b1;
            pend_sym_in   = rd_data_ff.sym;
         end
         if (issue) begin
            eval_in    = 1'b1;
            oor_in     = child_oor;
            nxt_idx_in = rd_addr;
            shift_in   = {shift_ff[BYTE_BITS-2:0], 1'b0};
            cnt_in     = cnt_ff + CW'(1);
         end else begin
            eval_in = 1'b0;
         end
      end

      if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end

      if (push) begin
         out_valid_in = 1'b1;
         out_data_in  = push_data;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_idx_ff    <= '0;
         eval_ff       <= 1'b0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_idx_ff    <= cur_idx_in;
         eval_ff       <= eval_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ent_ff  <= cur_ent_in;
      root_ff     <= root_in;
      nxt_idx_ff  <= nxt_idx_in;
      oor_ff      <= oor_in;
      shift_ff    <= shift_in;
      pend_sym_ff <= pend_sym_in;
      out_data_ff <= out_data_in;
   end

   assign status.bits_done  = bits_done;
   assign status.leaf_found = found_leaf;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: design/huffman_tree_walk_decoder.sv
// Channel   Dir  Payload                                               Handshake
// req_in    in   opcode, node_index, left/right_child, is_leaf,        valid/ready
//                leaf_symbol, code_byte
// rsp_out   out  symbol, last                                          valid/ready
//
// A decode request runs through the accept, eight bit steps, a final leaf check and
// a flush of the held last symbol. Each bit needs one dependent read of the
// synchronous table port, and a full output register stalls the walk and the flush.
// Reset clears the controller, the current node index (back to the root) and the
// output register; the node table is not cleared and holds garbage until loaded.
module huffman_tree_walk_decoder #(
   parameter int NODE_COUNT = 512
) (
   input logic       clock,
   input logic       reset,
   htw_req_if.sink   req_in,
   htw_rsp_if.source rsp_out
);
   import htw_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer for load, walk and flush.
   htw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_in.valid),
      .req_opcode (req_in.payload.opcode),
      .req_ready  (req_in.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Node table, walk registers and output register.
   htw_datapath #(
      .NODE_COUNT (NODE_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_in.payload),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_out.valid),
      .rsp_ready (rsp_out.ready),
      .rsp_data  (rsp_out.payload)
   );

endmodule

FILE: design/htw_checker.sv
module htw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [0:0] req_opcode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_symbol,
   input logic       rsp_last
);
   import htw_pkg::*;

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   // A stalled response keeps its symbol and flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol) && $stable(rsp_last))
      else $error("stalled response changed");

   // The block is ready for a request right after reset.
   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready)
      else $error("not ready after reset");

   // A load request never produces a response.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_opcode == OP_LOAD) |=> !$rose(rsp_valid))
      else $error("response after a load request");

   // A decode request keeps the block busy through its walk and flush.
   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_opcode == OP_DECODE) |-> ##10 !req_ready)
      else $error("request taken during a decode");

endmodule

bind huffman_tree_walk_decoder htw_checker u_htw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_in.valid),
   .req_ready  (req_in.ready),
   .req_opcode (req_in.payload.opcode),
   .rsp_valid  (rsp_out.valid),
   .rsp_ready  (rsp_out.ready),
   .rsp_symbol (rsp_out.payload.symbol),
   .rsp_last   (rsp_out.payload.last)
);

FILE: test/htw_decode_checker.sv
module htw_decode_checker #(
   parameter int NODE_COUNT = 512
) (
   input  logic clock,
   input  logic reset,
   htw_req_if   req_mon,
   htw_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import htw_pkg::*;

   // Private copy of the code tree and of the walk position.
   node_entry_type     code_tree [NODE_COUNT];
   logic [CHILD_W-1:0] walk_node;

   // Symbols still owed by the block, oldest first.
   rsp_payload_type    expected_syms [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Applies one accepted request: a node write, or a byte walked bit by bit.
   task automatic predict_request(input req_payload_type item);
      logic [BYTE_BITS-1:0] bits_left;
      logic [CHILD_W-1:0]   next_node;
      rsp_payload_type      sym_item;
      int                   emitted;
      if (item.opcode == OP_LOAD) begin
         // A write beyond the table is dropped.
         if (int'(item.node_index) < NODE_COUNT) begin
            code_tree[item.node_index] = '{left: item.left_child, right: item.right_child,
                                           leaf: item.is_leaf, sym: item.leaf_symbol};
         end
      end else begin
         bits_left = item.code_byte;
         emitted   = 0;
         for (int b = 0; b < BYTE_BITS; b++) begin
            if (int'(walk_node) >= NODE_COUNT) begin
               walk_node = '0;
            end
            next_node = ((bits_left & TOP_BIT) != 0) ? code_tree[walk_node].right
                                                      : code_tree[walk_node].left;
            // Step first, then test the node reached; a child off the table
            // sends the walk home without a symbol.
            if (int'(next_node) >= NODE_COUNT) begin
               walk_node = '0;
            end else if (code_tree[next_node].leaf) begin
               sym_item = '{symbol: code_tree[next_node].sym, last: 1'b0};
               expected_syms.insert(expected_syms.size(), sym_item);
               emitted++;
               walk_node = '0;
            end else begin
               walk_node = next_node;
            end
            bits_left = bits_left << 1;
         end
         // The final symbol of the byte carries the last flag.
         if (emitted > 0) begin
            expected_syms[expected_syms.size() - 1].last = 1'b1;
         end
      end
   endtask

   // Compare each accepted symbol, then fold in the request of the same edge.
   always @(posedge clock) begin : watch_channels
      rsp_payload_type want;
      if (reset) begin
         walk_node = '0;
         expected_syms.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_syms.size() == 0) begin
               $error("unexpected symbol: expected none, got symbol %02h last %0b",
                      rsp_mon.payload.symbol, rsp_mon.payload.last);
               fail_count++;
            end else begin
               want = expected_syms.pop_front();
               if (rsp_mon.payload.symbol !== want.symbol) begin
                  $error("symbol mismatch: expected %02h, got %02h",
                         want.symbol, rsp_mon.payload.symbol);
                  fail_count++;
               end
               if (rsp_mon.payload.last !== want.last) begin
                  $error("last mismatch: expected %0b, got %0b",
                         want.last, rsp_mon.payload.last);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_request(req_mon.payload);
         end
      end
      pending = expected_syms.size();
   end

endmodule

FILE: test/tb_huffman_tree_walk_decoder.sv
module tb_huffman_tree_walk_decoder;
   timeunit 1ns;
   timeprecision 1ps;
   import htw_pkg::*;

   localparam int NODE_COUNT    = 512;
   localparam int ITEM_TARGET   = 175;
   localparam int PHASE2_START  = 70;
   localparam int PHASE3_START  = 135;
   localparam int STALL_CYCLES  = 300;
   localparam int DRAIN_CYCLES  = 60;
   localparam int CYCLE_LIMIT   = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int   fail_count;
   int   pending;
   int   items_sent    = 0;
   int   send_idle_pct = 21;
   int   rcv_idle_pct  = 81;
   int   cycle_count   = 0;
   bit   stall_go      = 1'b0;
   bit   stall_active  = 1'b0;

   // Nodes written so far; the walk may only ever land on these.
   bit   written_map [NODE_COUNT];
   int   written_list [$];

   htw_req_if req_if ();
   htw_rsp_if rsp_if ();

   huffman_tree_walk_decoder #(
      .NODE_COUNT(NODE_COUNT)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_in (req_if.sink),
      .rsp_out(rsp_if.source)
   );

   htw_decode_checker #(
      .NODE_COUNT(NODE_COUNT)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_if),
      .rsp_mon   (rsp_if),
      .fail_count(fail_count),
      .pending   (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offers one request from a falling edge and returns at the falling edge
   // after it has been taken.
   task automatic send_request(input req_payload_type item);
      if (items_sent >= PHASE3_START) begin
         send_idle_pct = 0;
         rcv_idle_pct  = 0;
      end else if (items_sent >= PHASE2_START) begin
         send_idle_pct = 81;
         rcv_idle_pct  = 21;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.payload = item;
      req_if.valid   = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic load_node(input int idx, input int left_idx, input int right_idx,
                            input bit leaf, input int sym);
      req_payload_type item;
      item.opcode      = OP_LOAD;
      item.node_index  = CHILD_W'(idx);
      item.left_child  = CHILD_W'(left_idx);
      item.right_child = CHILD_W'(right_idx);
      item.is_leaf     = leaf;
      item.leaf_symbol = SYM_W'(sym);
      item.code_byte   = BYTE_BITS'($urandom_range(255));
      if (!written_map[idx]) begin
         written_map[idx] = 1'b1;
         written_list.insert(written_list.size(), idx);
      end
      send_request(item);
   endtask

   // The node fields ride along as noise on a decode request.
   task automatic decode_byte(input int code);
      req_payload_type item;
      item.opcode      = OP_DECODE;
      item.node_index  = CHILD_W'($urandom_range(NODE_COUNT - 1));
      item.left_child  = CHILD_W'($urandom_range(NODE_COUNT - 1));
      item.right_child = CHILD_W'($urandom_range(NODE_COUNT - 1));
      item.is_leaf     = 1'($urandom_range(1));
      item.leaf_symbol = SYM_W'($urandom_range(255));
      item.code_byte   = BYTE_BITS'(code);
      send_request(item);
   endtask

   function automatic int pick_written();
      return written_list[$urandom_range(written_list.size() - 1)];
   endfunction

   // Grows a full binary tree from the root by splitting random leaves, then
   // writes every node. Children always point inside the tree, so the walk
   // never reaches an unwritten entry.
   task automatic build_random_tree();
      int                    node_ids [$];
      int                    left_ids [$];
      int                    right_ids [$];
      bit                    leaf_flags [$];
      bit [NODE_COUNT-1:0]   taken;
      int                    leaves;
      int                    spot;
      int                    cand;
      taken  = '0;
      leaves = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 7);
      node_ids.insert(node_ids.size(), 0);
      left_ids.insert(left_ids.size(), 0);
      right_ids.insert(right_ids.size(), 0);
      leaf_flags.insert(leaf_flags.size(), 1'b1);
      taken[0] = 1'b1;
      for (int k = 1; k < leaves; k++) begin
         do spot = $urandom_range(node_ids.size() - 1); while (!leaf_flags[spot]);
         leaf_flags[spot] = 1'b0;
         repeat (2) begin
            do cand = $urandom_range(1, NODE_COUNT - 1); while (taken[cand]);
            taken[cand] = 1'b1;
            node_ids.insert(node_ids.size(), cand);
            left_ids.insert(left_ids.size(), 0);
            right_ids.insert(right_ids.size(), 0);
            leaf_flags.insert(leaf_flags.size(), 1'b1);
         end
         left_ids[spot]  = node_ids[node_ids.size() - 2];
         right_ids[spot] = node_ids[node_ids.size() - 1];
      end
      // Leaf children only matter when the root itself is a leaf.
      for (int i = node_ids.size() - 1; i >= 0; i--) begin
         if (leaf_flags[i]) begin
            left_ids[i]  = node_ids[$urandom_range(node_ids.size() - 1)];
            right_ids[i] = node_ids[$urandom_range(node_ids.size() - 1)];
         end
         load_node(node_ids[i], left_ids[i], right_ids[i], leaf_flags[i], $urandom_range(255));
      end
   endtask

   // Symbol receiver: decides at the rising edge, drives at the falling edge.
   initial begin : rsp_receiver
      bit take;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         take = !stall_active && ($urandom_range(99) >= rcv_idle_pct);
         @(negedge clock);
         rsp_if.ready = take;
      end
   end

   // One long hold-off on the symbol side, counted here in cycles.
   initial begin : rsp_holdoff
      wait (stall_go);
      @(negedge clock);
      stall_active = 1'b1;
      repeat (STALL_CYCLES) @(negedge clock);
      stall_active = 1'b0;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int node_a;
      int node_b;
      int node;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // A root that is itself a leaf steps onto its child, here itself,
      // so every bit emits a symbol.
      load_node(0, 0, 0, 1'b1, 8'h00);
      decode_byte(8'h00);
      decode_byte(8'hFF);

      // Small tree with the top index and the top symbol value.
      load_node(511, 511, 511, 1'b1, 8'hFF);
      load_node(2, 0, 0, 1'b1, 8'h3C);
      load_node(3, 0, 0, 1'b1, 8'hA5);
      load_node(1, 2, 3, 1'b0, 8'hFF);
      load_node(0, 511, 1, 1'b0, 8'h00);
      decode_byte(8'hFF);
      decode_byte(8'h00);
      // The byte ends halfway down a code; the next one finishes it.
      decode_byte(8'h01);
      decode_byte(8'h80);

      // A root that loops onto itself reaches no leaf, so the byte is silent.
      load_node(0, 0, 0, 1'b0, 8'h5A);
      decode_byte(8'h96);
      load_node(0, 511, 1, 1'b0, 8'h00);
      decode_byte(8'hA5);
      decode_byte(8'h6D);

      // Random trees with random code bytes, mixed with leaf rewrites and
      // stray bytes.
      while (items_sent < ITEM_TARGET) begin
         if (!stall_go && items_sent >= PHASE3_START) begin
            // Both root children are leaves, so each byte gives eight symbols
            // and backs up the block while the receiver holds off.
            stall_go = 1'b1;
            node_a   = $urandom_range(1, 255);
            node_b   = $urandom_range(256, NODE_COUNT - 1);
            load_node(node_a, 0, 0, 1'b1, $urandom_range(255));
            load_node(node_b, node_a, node_b, 1'b1, $urandom_range(255));
            load_node(0, node_a, node_b, 1'b0, $urandom_range(255));
            repeat (12) decode_byte($urandom_range(255));
         end
         case ($urandom_range(9))
            0, 1: begin
               node = pick_written();
               load_node(node, pick_written(), pick_written(), 1'b1, $urandom_range(255));
            end
            2: begin
               repeat ($urandom_range(1, 3)) decode_byte($urandom_range(255));
            end
            default: begin
               build_random_tree();
               repeat ($urandom_range(3, 10)) decode_byte($urandom_range(255));
            end
         endcase
      end
      req_if.valid = 1'b0;

      // Let outstanding symbols drain, then give the block time to show
      // anything extra.
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
